### sv/session_message_depacketizer_macros.svh
// Assertion macros shared by the depacketizer RTL
`ifndef SESSION_MESSAGE_DEPACKETIZER_MACROS_SVH
`define SESSION_MESSAGE_DEPACKETIZER_MACROS_SVH

// same-cycle implication
`define SMD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/smd_pkg.sv
// Types and constants of the session message depacketizer
package smd_pkg;

    localparam int SESSIONS       = 1024;
    localparam int SESS_BITS      = $clog2(SESSIONS);
    localparam int WORD_BYTES     = 64;
    localparam int TARGET_BITS    = 8;
    localparam int TAKE_BITS      = $clog2(WORD_BYTES + 1);
    localparam int FRAG_BITS      = 24;
    localparam logic [FRAG_BITS-1:0] MAX_FRAG_RESET = FRAG_BITS'(8 * 1024 * 1024 - 1);

    typedef enum logic [2:0] {
        KIND_DATA      = 3'd0,
        KIND_HEADER    = 3'd1,
        KIND_START_MSG = 3'd2,
        KIND_START_FRG = 3'd3,
        KIND_END_FRG   = 3'd4
    } t_kind;

    typedef struct packed {
        logic [SESS_BITS-1:0]   session;
        logic [63:0]            word_data;
        logic                   word_last;
        logic [31:0]            header_count;
        logic [TARGET_BITS-1:0] header_target;
    } t_in_word;

    typedef struct packed {
        t_kind                  kind;
        logic [SESS_BITS-1:0]   out_session;
        logic [TARGET_BITS-1:0] out_dest;
        logic [31:0]            length;
        logic [63:0]            out_data;
        logic                   out_word_last;
        logic                   run_end;
    } t_out_word;

    typedef struct packed {
        logic [31:0]            remaining;
        logic [TARGET_BITS-1:0] target;
    } t_tab_entry;

endpackage

### sv/session_message_depacketizer.sv
// Session message depacketizer: per-session message/fragment tracking over a table RAM
//
//  channel | direction | handshake                | payload
//  in      | input     | i_in_valid / o_in_stall  | i_in_word  (smd_pkg::t_in_word)
//  out     | output    | o_out_valid / i_out_stall| o_out_word (smd_pkg::t_out_word)
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_data (max_fragment_bytes)
//
// A word whose item yields no result, or one result while the output is not stalled,
// is taken every cycle; an item with several results (up to four) holds the work
// stage until each result has gone out, paced by the single output register.
// After reset a clearing pass zeroes the session table with the input stalled;
// config writes are taken during it.
// The table read is issued when a word is taken; a write-back in that same cycle
// to the same session is forwarded.
`include "session_message_depacketizer_macros.svh"

module session_message_depacketizer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  smd_pkg::t_in_word                   i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output smd_pkg::t_out_word                  o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [smd_pkg::FRAG_BITS-1:0]       i_cfg_data
);

    localparam int P_HDR  = 0;
    localparam int P_SMSG = 1;
    localparam int P_SFRG = 2;
    localparam int P_DATA = 3;
    localparam int P_EFRG = 4;
    localparam int NPLAN  = 5;

    localparam logic [31:0] BPW32 = 32'(smd_pkg::WORD_BYTES);
    localparam logic [smd_pkg::FRAG_BITS-1:0] BPWF =
        smd_pkg::FRAG_BITS'(smd_pkg::WORD_BYTES);

    // session table
    smd_pkg::t_tab_entry                  mem [smd_pkg::SESSIONS];
    smd_pkg::t_tab_entry                  r_rd_data;

    logic                                 r_clr_busy;
    logic [smd_pkg::SESS_BITS-1:0]        r_clr_cnt;
    logic [smd_pkg::FRAG_BITS-1:0]        r_max_frag;

    // work stage
    logic                                 r_s1_valid;
    smd_pkg::t_in_word                    r_s1_item;
    logic                                 r_s1_fwd_hit;
    smd_pkg::t_tab_entry                  r_s1_fwd_data;
    logic [NPLAN-1:0]                     r_sent;

    // fragment state
    logic                                 r_in_frag;
    logic [smd_pkg::SESS_BITS-1:0]        r_cur_session;
    logic [31:0]                          r_cur_rem;
    logic [smd_pkg::TARGET_BITS-1:0]      r_cur_tgt;
    logic [smd_pkg::FRAG_BITS-1:0]        r_frag_bytes;

    logic                                 r_out_valid;
    smd_pkg::t_out_word                   r_out_word;

    logic                                 in_accept;
    logic                                 out_free;
    smd_pkg::t_tab_entry                  tab;
    logic                                 tab_zero;
    logic [smd_pkg::SESS_BITS-1:0]        sess;
    logic [31:0]                          rem;
    logic [smd_pkg::TARGET_BITS-1:0]      tgt;
    logic [smd_pkg::FRAG_BITS-1:0]        fb;
    logic                                 is_hdr;
    logic                                 tgt_mem;
    logic [smd_pkg::TAKE_BITS-1:0]        take;
    logic [31:0]                          n_rem;
    logic [smd_pkg::FRAG_BITS-1:0]        n_fb;
    logic [smd_pkg::FRAG_BITS-1:0]        thr;
    logic                                 done;
    logic [NPLAN-1:0]                     plan;
    logic [NPLAN-1:0]                     pending;
    logic [NPLAN-1:0]                     rest;
    logic                                 emit;
    logic                                 s1_finish;
    smd_pkg::t_out_word                   res;
    logic                                 wr_en;
    logic [smd_pkg::SESS_BITS-1:0]        wr_addr;
    smd_pkg::t_tab_entry                  wr_data;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign o_in_stall  = r_clr_busy || (r_s1_valid && !s1_finish);
    assign in_accept   = i_in_valid && !o_in_stall;

    assign thr = (r_max_frag > BPWF) ? r_max_frag - BPWF : '0;

    // plan of results for the word in the work stage
    always_comb begin
        tab      = r_s1_fwd_hit ? r_s1_fwd_data : r_rd_data;
        tab_zero = (tab.remaining == '0);
        is_hdr   = !r_in_frag && tab_zero;
        if (r_in_frag) begin
            sess = r_cur_session;
            rem  = r_cur_rem;
            tgt  = r_cur_tgt;
            fb   = r_frag_bytes;
        end else if (tab_zero) begin
            sess = r_s1_item.session;
            rem  = r_s1_item.header_count;
            tgt  = r_s1_item.header_target;
            fb   = '0;
        end else begin
            sess = r_s1_item.session;
            rem  = tab.remaining;
            tgt  = tab.target;
            fb   = '0;
        end
        tgt_mem = (tgt == '0);
        take    = (rem < BPW32) ? rem[smd_pkg::TAKE_BITS-1:0]
                                : smd_pkg::TAKE_BITS'(smd_pkg::WORD_BYTES);
        if (is_hdr) begin
            n_rem = rem;
            n_fb  = '0;
            done  = r_s1_item.word_last || (rem == '0);
        end else begin
            n_rem = rem - 32'(take);
            n_fb  = fb + smd_pkg::FRAG_BITS'(take);
            done  = r_s1_item.word_last || (n_rem == '0) || (n_fb >= thr);
        end
        plan         = '0;
        plan[P_HDR]  = is_hdr && tgt_mem;
        plan[P_SMSG] = is_hdr && tgt_mem;
        plan[P_SFRG] = !r_in_frag && tgt_mem;
        plan[P_DATA] = !is_hdr;
        plan[P_EFRG] = done && tgt_mem;
    end

    assign pending   = r_s1_valid ? (plan & ~r_sent) : '0;
    assign emit      = (pending != '0) && out_free;
    assign s1_finish = r_s1_valid && ((pending == '0) || (emit && (rest == '0)));

    // next result: first pending entry in output order
    always_comb begin
        res               = '0;
        rest              = pending;
        res.out_session   = sess;
        if (pending[P_HDR]) begin
            res.kind      = smd_pkg::KIND_HEADER;
            res.out_dest  = tgt;
            res.length    = r_s1_item.header_count;
            res.out_data  = r_s1_item.word_data;
            rest[P_HDR]   = 1'b0;
        end else if (pending[P_SMSG]) begin
            res.kind      = smd_pkg::KIND_START_MSG;
            res.length    = r_s1_item.header_count;
            rest[P_SMSG]  = 1'b0;
        end else if (pending[P_SFRG]) begin
            res.kind      = smd_pkg::KIND_START_FRG;
            res.length    = 32'(r_max_frag);
            rest[P_SFRG]  = 1'b0;
        end else if (pending[P_DATA]) begin
            res.kind          = smd_pkg::KIND_DATA;
            res.out_dest      = tgt;
            res.out_data      = r_s1_item.word_data;
            res.out_word_last = r_s1_item.word_last;
            rest[P_DATA]      = 1'b0;
        end else begin
            res.kind      = smd_pkg::KIND_END_FRG;
            res.length    = 32'(n_fb);
            rest[P_EFRG]  = 1'b0;
        end
        res.run_end = (rest == '0);
    end

    // table write port: clearing pass or fragment close
    always_comb begin
        wr_en             = r_clr_busy || (s1_finish && done);
        wr_addr           = r_clr_busy ? r_clr_cnt : sess;
        wr_data.remaining = r_clr_busy ? '0 : n_rem;
        wr_data.target    = r_clr_busy ? '0 : tgt;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (in_accept) begin
            r_rd_data <= mem[i_in_word.session];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy    <= 1'b1;
            r_clr_cnt     <= '0;
            r_max_frag    <= smd_pkg::MAX_FRAG_RESET;
            r_s1_valid    <= 1'b0;
            r_sent        <= '0;
            r_in_frag     <= 1'b0;
            r_cur_session <= '0;
            r_cur_rem     <= '0;
            r_cur_tgt     <= '0;
            r_frag_bytes  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == smd_pkg::SESS_BITS'(smd_pkg::SESSIONS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_frag <= i_cfg_data;
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (s1_finish) begin
                r_sent        <= '0;
                r_in_frag     <= !done;
                r_cur_session <= sess;
                r_cur_rem     <= n_rem;
                r_cur_tgt     <= tgt;
                r_frag_bytes  <= done ? '0 : n_fb;
            end else if (emit) begin
                r_sent <= r_sent | (pending & ~rest);
            end

            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_finish) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word <= res;
        end
        if (in_accept) begin
            r_s1_item     <= i_in_word;
            r_s1_fwd_hit  <= s1_finish && done && (sess == i_in_word.session);
            r_s1_fwd_data <= wr_data;
        end
    end

    `SMD_ASSERT_IMPLY(a_clr_stall, i_clk, i_rst_n, r_clr_busy, o_in_stall, "word taken during clear")
    `SMD_ASSERT_IMPLY(a_sent_plan, i_clk, i_rst_n, r_s1_valid, (r_sent & ~plan) == '0, "sent outside plan")
    `SMD_ASSERT_IMPLY(a_wr_src, i_clk, i_rst_n, wr_en, r_clr_busy || s1_finish, "stray table write")
    `SMD_ASSERT_NEXT(a_frag_open, i_clk, i_rst_n, s1_finish && !done, r_in_frag, "fragment not held open")

endmodule

### tb/testbench.sv
// Testbench for session_message_depacketizer: directed table, random messages, scoreboard
`timescale 1ns / 100ps

module testbench;

    localparam int IDLE_LIMIT   = 4000;   // covers the table clearing pass after reset
    localparam int SETTLE_TICKS = 16;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_WORDS  = 26;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_op;

    typedef struct {
        t_row_op              op;
        smd_pkg::t_in_word    w;
        int                   n_res;   // typed result count, -1 = predictor only
        smd_pkg::t_kind       kind;    // typed kind of the first result
        logic [31:0]          len;     // typed length of the first result, or register value
    } t_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    smd_pkg::t_in_word             i_in_word = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    smd_pkg::t_out_word            o_out_word;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [smd_pkg::FRAG_BITS-1:0] i_cfg_data = '0;

    session_message_depacketizer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the session tables and the open fragment
    logic [31:0]                     owed_bytes [smd_pkg::SESSIONS];
    logic [smd_pkg::TARGET_BITS-1:0] owed_target [smd_pkg::SESSIONS];
    logic                            in_frag;
    logic [smd_pkg::SESS_BITS-1:0]   frag_sess;
    logic [31:0]                     frag_owed;
    logic [smd_pkg::TARGET_BITS-1:0] frag_target;
    logic [31:0]                     frag_copied;
    logic [smd_pkg::FRAG_BITS-1:0]   max_frag;

    smd_pkg::t_out_word expected_words[$];
    t_row               stim_rows[$];

    int  n_mismatch = 0;
    int  words_in = 0;
    int  words_out = 0;
    int  reg_writes = 0;
    int  idle_ticks = 0;
    bit  idling_on = 1'b1;
    int  burst_left = 0;
    bit  burst_stall = 1'b0;

    function automatic void note_mismatch(string msg);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("MISMATCH @%0t: %s", $time, msg);
    endfunction

    function automatic string word_str(smd_pkg::t_out_word r);
        return $sformatf("kind=%0d sess=%0d dest=%0d len=%0h data=%h last=%b end=%b",
                         r.kind, r.out_session, r.out_dest, r.length, r.out_data,
                         r.out_word_last, r.run_end);
    endfunction

    function automatic void push_result(smd_pkg::t_kind k,
                                        logic [smd_pkg::TARGET_BITS-1:0] dest,
                                        logic [31:0] len, logic [63:0] d, logic last);
        smd_pkg::t_out_word r;
        r.kind          = k;
        r.out_session   = frag_sess;
        r.out_dest      = dest;
        r.length        = len;
        r.out_data      = d;
        r.out_word_last = last;
        r.run_end       = 1'b0;
        expected_words.push_back(r);
    endfunction

    // data word of the open fragment; returns 1 when the fragment closes
    function automatic logic forward_data(logic [63:0] d, logic last);
        logic [31:0] take;
        logic [31:0] limit;
        take  = (frag_owed < 32'(smd_pkg::WORD_BYTES)) ? frag_owed
                                                       : 32'(smd_pkg::WORD_BYTES);
        limit = (32'(max_frag) > 32'(smd_pkg::WORD_BYTES)) ?
                32'(max_frag) - 32'(smd_pkg::WORD_BYTES) : 32'd0;
        push_result(smd_pkg::KIND_DATA, frag_target, 32'd0, d, last);
        frag_owed   -= take;
        frag_copied += take;
        return last || frag_owed == 32'd0 || frag_copied >= limit;
    endfunction

    // expected results of one accepted word; returns how many were queued
    function automatic int depacketize_word(smd_pkg::t_in_word w);
        int                 first;
        logic               done;
        smd_pkg::t_out_word r;
        first = expected_words.size();
        if (in_frag) begin
            done = forward_data(w.word_data, w.word_last);
        end else begin
            frag_sess   = w.session;
            frag_owed   = owed_bytes[frag_sess];
            frag_copied = 32'd0;
            if (frag_owed == 32'd0) begin
                // header word
                frag_target = w.header_target;
                frag_owed   = w.header_count;
                owed_target[frag_sess] = frag_target;
                if (frag_target == '0) begin
                    push_result(smd_pkg::KIND_HEADER, frag_target, w.header_count,
                                w.word_data, 1'b0);
                    push_result(smd_pkg::KIND_START_MSG, '0, w.header_count, 64'd0, 1'b0);
                    push_result(smd_pkg::KIND_START_FRG, '0, 32'(max_frag), 64'd0, 1'b0);
                end
                done = w.word_last || frag_owed == 32'd0;
            end else begin
                frag_target = owed_target[frag_sess];
                if (frag_target == '0)
                    push_result(smd_pkg::KIND_START_FRG, '0, 32'(max_frag), 64'd0, 1'b0);
                done = forward_data(w.word_data, w.word_last);
            end
            in_frag = 1'b1;
        end
        if (done) begin
            if (frag_target == '0)
                push_result(smd_pkg::KIND_END_FRG, '0, frag_copied, 64'd0, 1'b0);
            owed_bytes[frag_sess] = frag_owed;
            in_frag     = 1'b0;
            frag_copied = 32'd0;
        end
        if (expected_words.size() > first) begin
            r = expected_words.pop_back();
            r.run_end = 1'b1;
            expected_words.push_back(r);
        end
        return expected_words.size() - first;
    endfunction

    function automatic void add_word(int s, logic [63:0] d, logic last, logic [31:0] cnt,
                                     int tgt, int n_res, smd_pkg::t_kind k,
                                     logic [31:0] len);
        t_row row;
        row.op              = ROW_WORD;
        row.w.session       = smd_pkg::SESS_BITS'(s);
        row.w.word_data     = d;
        row.w.word_last     = last;
        row.w.header_count  = cnt;
        row.w.header_target = smd_pkg::TARGET_BITS'(tgt);
        row.n_res           = n_res;
        row.kind            = k;
        row.len             = len;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [31:0] value);
        t_row row;
        row       = '{ROW_CFG, '0, -1, smd_pkg::KIND_DATA, value};
        stim_rows.push_back(row);
    endfunction

    // sender: optional idle burst, then hold the word until taken
    task automatic send_word(input smd_pkg::t_in_word w, output int first, output int cnt);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        first = expected_words.size();
        cnt   = depacketize_word(w);
        words_in++;
    endtask

    // drop valid, wait for every expected word, then let the pipe settle
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_max_frag(input logic [smd_pkg::FRAG_BITS-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        max_frag = value;
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver stall bursts
    always @(negedge i_clk) begin
        if (burst_left == 0) begin
            burst_stall = idling_on && ($urandom_range(0, 2) == 0);
            burst_left  = $urandom_range(1, 9);
        end
        burst_left--;
        i_out_stall <= burst_stall;
    end

    // output checker
    always @(posedge i_clk) begin
        smd_pkg::t_out_word exp_word;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_out++;
            if (expected_words.size() == 0) begin
                note_mismatch({"unexpected word: ", word_str(o_out_word)});
            end else begin
                exp_word = expected_words.pop_front();
                if (o_out_word !== exp_word)
                    note_mismatch({"expected ", word_str(exp_word), " got ",
                                   word_str(o_out_word)});
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_ticks <= 0;
        else
            idle_ticks <= idle_ticks + 1;
        if (idle_ticks >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int                            first;
        int                            cnt;
        t_row                          row;
        smd_pkg::t_out_word            r;
        smd_pkg::t_in_word             w;
        logic [smd_pkg::SESS_BITS-1:0] s;
        int                            pick;

        for (int i = 0; i < smd_pkg::SESSIONS; i++) begin
            owed_bytes[i]  = '0;
            owed_target[i] = '0;
        end
        in_frag     = 1'b0;
        frag_sess   = '0;
        frag_owed   = '0;
        frag_target = '0;
        frag_copied = '0;
        max_frag    = smd_pkg::MAX_FRAG_RESET;

        // header on memory target, data, last, resume, owed bytes run out
        add_word(5, 64'h0123_4567_89AB_CDEF, 1'b0, 32'd200, 0, 3, smd_pkg::KIND_HEADER,
                 32'd200);
        add_word(777, 64'h5A5A_A5A5_0F0F_F0F0, 1'b0, 32'd0, 0, 1, smd_pkg::KIND_DATA, 32'd0);
        add_word(5, 64'hFEDC_BA98_7654_3210, 1'b1, 32'd0, 0, 2, smd_pkg::KIND_DATA, 32'd0);
        add_word(5, 64'h1111_2222_3333_4444, 1'b0, 32'd0, 0, 2, smd_pkg::KIND_START_FRG,
                 32'(smd_pkg::MAX_FRAG_RESET));
        add_word(5, 64'h9999_8888_7777_6666, 1'b0, 32'd0, 0, 2, smd_pkg::KIND_DATA, 32'd0);
        // zero count header: all four notices
        add_word(1023, '1, 1'b0, 32'd0, 0, 4, smd_pkg::KIND_HEADER, 32'd0);
        // stream target: silent header, data only
        add_word(0, 64'h0, 1'b0, 32'd100, 255, 0, smd_pkg::KIND_DATA, 32'd0);
        add_word(0, 64'h0, 1'b1, 32'd0, 0, 1, smd_pkg::KIND_DATA, 32'd0);
        add_word(0, 64'hDEAD_BEEF_CAFE_F00D, 1'b0, 32'd0, 0, 1, smd_pkg::KIND_DATA, 32'd0);
        // header word with last closes its fragment at once
        add_word(2, 64'h0BAD_F00D_1234_5678, 1'b1, 32'd1000, 0, 4, smd_pkg::KIND_HEADER,
                 32'd1000);
        add_word(2, '1, 1'b1, '1, 255, 3, smd_pkg::KIND_START_FRG,
                 32'(smd_pkg::MAX_FRAG_RESET));
        // smallest limit: every data word closes the fragment
        add_cfg(32'd1);
        add_word(2, 64'h2, 1'b0, 32'd0, 0, 3, smd_pkg::KIND_START_FRG, 32'd1);
        add_word(3, 64'h3, 1'b0, 32'hFFFF_FFFF, 8'h80, 0, smd_pkg::KIND_DATA, 32'd0);
        add_word(3, 64'h4, 1'b0, 32'd0, 0, 1, smd_pkg::KIND_DATA, 32'd0);
        add_cfg(32'hFF_FFFF);
        add_word(4, 64'h5, 1'b0, 32'd130, 0, 3, smd_pkg::KIND_HEADER, 32'd130);
        add_word(4, 64'h6, 1'b0, 32'd0, 0, -1, smd_pkg::KIND_DATA, 32'd0);
        add_word(4, 64'h7, 1'b0, 32'd0, 0, -1, smd_pkg::KIND_DATA, 32'd0);
        add_word(4, 64'h8, 1'b0, 32'd0, 0, -1, smd_pkg::KIND_DATA, 32'd0);
        // limit reached after three words
        add_cfg(32'd200);
        add_word(6, 64'h9, 1'b0, 32'd1000, 0, 3, smd_pkg::KIND_HEADER, 32'd1000);
        add_word(6, 64'hA, 1'b0, 32'd0, 0, -1, smd_pkg::KIND_DATA, 32'd0);
        add_word(6, 64'hB, 1'b0, 32'd0, 0, -1, smd_pkg::KIND_DATA, 32'd0);
        add_word(6, 64'hC, 1'b0, 32'd0, 0, -1, smd_pkg::KIND_DATA, 32'd0);
        add_cfg(32'd65);
        add_word(6, 64'hD, 1'b0, 32'd0, 0, 3, smd_pkg::KIND_START_FRG, 32'd65);
        add_word(3, 64'hE, 1'b0, 32'd0, 0, 1, smd_pkg::KIND_DATA, 32'd0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.op == ROW_CFG) begin
                write_max_frag(row.len[smd_pkg::FRAG_BITS-1:0]);
            end else begin
                send_word(row.w, first, cnt);
                if (row.n_res >= 0) begin
                    if (cnt != row.n_res) begin
                        note_mismatch($sformatf("row %0d: predicted %0d words, table %0d",
                                                i, cnt, row.n_res));
                    end else if (cnt > 0) begin
                        r        = expected_words[first];
                        r.kind   = row.kind;
                        r.length = row.len;
                        expected_words[first] = r;
                    end
                end
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p % 4)
                0:       write_max_frag(smd_pkg::FRAG_BITS'(
                             $urandom_range(1, smd_pkg::WORD_BYTES)));
                1:       write_max_frag(smd_pkg::FRAG_BITS'($urandom_range(65, 1024)));
                2:       write_max_frag(smd_pkg::FRAG_BITS'($urandom_range(1, 24'hFF_FFFF)));
                default: write_max_frag(24'hFF_FFFF);
            endcase
            if (p == RAND_PHASES - 1)
                idling_on = 1'b0;
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (p == 2 && k == PHASE_WORDS / 2)
                    wait_drained();
                w.session       = smd_pkg::SESS_BITS'($urandom);
                w.word_data     = {$urandom, $urandom};
                w.word_last     = ($urandom_range(0, 7) == 0);
                w.header_count  = $urandom;
                w.header_target = smd_pkg::TARGET_BITS'($urandom);
                if (!in_frag) begin
                    s = ($urandom_range(0, 4) != 0) ?
                        smd_pkg::SESS_BITS'($urandom_range(0, 7)) :
                        smd_pkg::SESS_BITS'($urandom);
                    w.session = s;
                    if (owed_bytes[s] == 32'd0) begin
                        // header: mostly short messages on the memory target
                        pick = $urandom_range(0, 9);
                        if (pick < 7)
                            w.header_count = $urandom_range(1, 400);
                        else if (pick == 7)
                            w.header_count = 32'd0;
                        else if (pick == 8)
                            w.header_count = $urandom_range(401, 5000);
                        w.header_target = ($urandom_range(0, 3) != 0) ? '0 :
                                          smd_pkg::TARGET_BITS'($urandom_range(1, 255));
                        w.word_last = ($urandom_range(0, 9) == 0);
                    end
                end
                send_word(w, first, cnt);
            end
        end

        wait_drained();
        $display("covered %0d input words, %0d result words, %0d limit writes",
                 words_in, words_out, reg_writes);
        $display("headers, notices, stream targets, early last and fragment limits exercised");
        if (n_mismatch == 0 && expected_words.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d words still expected",
                     n_mismatch, expected_words.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
